/* rtl/front_compress_bigram_encoder_defines.svh */
// shared assertion macros
`ifndef FRONT_COMPRESS_BIGRAM_ENCODER_DEFINES_SVH
`define FRONT_COMPRESS_BIGRAM_ENCODER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define FBE_ASSERT_SAME(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("fbe assertion failed");
`define FBE_ASSERT_NEXT(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("fbe assertion failed");
`else
`define FBE_ASSERT_SAME(label, a, c)
`define FBE_ASSERT_NEXT(label, a, c)
`endif
`endif

/* rtl/fbe_pkg.sv */
package fbe_pkg;
	localparam int PATH_DEPTH_DEF   = 1024;
	localparam int BIGRAM_PAIRS_DEF = 128;
	localparam int COUNT_OFFSET     = 14;
	localparam logic [7:0] SWITCH_CODE = 8'd30;
	localparam logic [7:0] HIGH_BIT    = 8'd128;
	localparam logic [6:0] SPACE_CHAR  = 7'h20;
	localparam logic [6:0] QMARK_CHAR  = 7'h3f;

	localparam logic [1:0] KIND_TABLE = 2'd0;
	localparam logic [1:0] KIND_CHAR  = 2'd1;
	localparam logic [1:0] KIND_EOL   = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHAR,
		ST_SEARCH,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic hit;
		logic stop;
	} cell_stat_t;

	typedef struct packed {
		logic done;
		logic found;
	} srch_stat_t;

	function automatic logic [6:0] clean_char(input logic [7:0] c);
		logic [6:0] r;
		if (c[7]) begin
			r = c[6:0];
		end else if (c <= 8'd30) begin
			r = QMARK_CHAR;
		end else begin
			r = c[6:0];
		end
		return r;
	endfunction
endpackage

/* rtl/fbe_pair_cell.sv */
module fbe_pair_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_first,
	input  logic                wr_second,
	input  logic [7:0]          wr_byte,
	input  logic                tok_in,
	input  logic [6:0]          a,
	input  logic [6:0]          b,
	output logic                tok_out,
	output logic                busy,
	output fbe_pkg::cell_stat_t stat
);
	logic [7:0] first_q;
	logic [7:0] second_q;
	logic       tok_q;
	logic       is_end;
	logic       is_match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= '0;
			second_q <= '0;
			tok_q    <= 1'b0;
		end else begin
			if (wr_first) begin
				first_q <= wr_byte;
			end
			if (wr_second) begin
				second_q <= wr_byte;
			end
			tok_q <= tok_in;
		end
	end

	assign is_end   = (first_q == 8'd0);
	assign is_match = (first_q == {1'b0, a}) && (second_q == {1'b0, b});
	// token moves on only past a live pair that does not match
	assign tok_out   = tok_q && !is_end && !is_match;
	assign busy      = tok_q;
	assign stat.hit  = tok_q && !is_end && is_match;
	assign stat.stop = tok_q && (is_end || is_match);
endmodule

/* rtl/fbe_pair_row.sv */
`include "front_compress_bigram_encoder_defines.svh"
module fbe_pair_row #(
	parameter int BIGRAM_PAIRS = fbe_pkg::BIGRAM_PAIRS_DEF,
	parameter int IW = (BIGRAM_PAIRS > 1) ? $clog2(BIGRAM_PAIRS) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [7:0]          wr_addr,
	input  logic [7:0]          wr_byte,
	input  logic                start,
	input  logic [6:0]          a,
	input  logic [6:0]          b,
	output fbe_pkg::srch_stat_t srch,
	output logic [IW-1:0]       idx
);
	logic [BIGRAM_PAIRS:0]   tok;
	logic [BIGRAM_PAIRS-1:0] busy;
	logic [BIGRAM_PAIRS-1:0] hit;
	logic [BIGRAM_PAIRS-1:0] stop;

	assign tok[0] = start;

	for (genvar k = 0; k < BIGRAM_PAIRS; k++) begin : g_cell
		fbe_pkg::cell_stat_t st;
		fbe_pair_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr_first (wr_en && (wr_addr[7:1] == 7'(k)) && !wr_addr[0]),
			.wr_second(wr_en && (wr_addr[7:1] == 7'(k)) && wr_addr[0]),
			.wr_byte  (wr_byte),
			.tok_in   (tok[k]),
			.a        (a),
			.b        (b),
			.tok_out  (tok[k+1]),
			.busy     (busy[k]),
			.stat     (st)
		);
		assign hit[k]  = st.hit;
		assign stop[k] = st.stop;
	end

	// at most one hit is set, so an or of the indexes encodes it
	always_comb begin
		idx = '0;
		for (int k = 0; k < BIGRAM_PAIRS; k++) begin
			if (hit[k]) begin
				idx = idx | IW'(k);
			end
		end
	end

	assign srch.done  = (|stop) || tok[BIGRAM_PAIRS];
	assign srch.found = |hit;

	`FBE_ASSERT_SAME(a_one_token, 1'b1, $onehot0(busy))
	`FBE_ASSERT_SAME(a_hit_done, srch.found, srch.done)
endmodule

/* rtl/front_compress_bigram_encoder.sv */
// a table byte is shown on the output in the cycle after its request is taken
// a path character passes through the char state, then, when a bigram pair is
// searched, through the search state while the token walks the pair chain; its
// output bytes leave from the emit state. one request is in work at a time; throughput
// is set by the pair chain walk and the output burst (up to five bytes)
// reset: control and the bigram table clear at once; path memory entry zero reads as space
`include "front_compress_bigram_encoder_defines.svh"
module front_compress_bigram_encoder #(
	parameter int PATH_DEPTH   = fbe_pkg::PATH_DEPTH_DEF,
	parameter int BIGRAM_PAIRS = fbe_pkg::BIGRAM_PAIRS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] kind,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       last_of_run
);
	localparam int PW  = $clog2(PATH_DEPTH);
	localparam int CPW = $clog2(PATH_DEPTH + 1);
	localparam int IW  = (BIGRAM_PAIRS > 1) ? $clog2(BIGRAM_PAIRS) : 1;

	fbe_pkg::state_t state_q, state_d;

	logic [CPW-1:0] char_pos_q;
	logic [CPW-1:0] prev_len_q;
	logic [CPW-1:0] prev_cnt_q;
	logic           still_q;
	logic [6:0]     pend_q;
	logic           pend_v_q;
	logic [8:0]     fill_q;
	logic           zero_wr_q;
	logic [6:0]     c_q;
	logic [7:0]     buf_q [5];
	logic [2:0]     n_q;
	logic [2:0]     e_q;

	logic [6:0]     path_mem [PATH_DEPTH];
	logic [6:0]     rd_q;
	logic           mem_we;

	logic           in_acc;
	logic           out_acc;
	logic           last_e;
	logic           pos_ok;
	logic           fill_ok;
	logic           tab_we;
	logic           start;
	logic [31:0]    d;
	logic           d_small;
	logic [6:0]     ent;
	logic           match;

	fbe_pkg::srch_stat_t srch;
	logic [IW-1:0]       idx;

	assign in_ready    = (state_q == fbe_pkg::ST_IDLE);
	assign in_acc      = in_valid && in_ready;
	assign out_valid   = (state_q == fbe_pkg::ST_EMIT);
	assign out_acc     = out_valid && out_ready;
	assign out_byte    = buf_q[e_q];
	assign last_e      = (e_q == (n_q - 3'd1));
	assign last_of_run = last_e;

	assign pos_ok  = (char_pos_q < CPW'(PATH_DEPTH));
	assign fill_ok = (fill_q < 9'(2 * BIGRAM_PAIRS));
	assign tab_we  = in_acc && (kind == fbe_pkg::KIND_TABLE) && fill_ok;
	assign start   = (state_q == fbe_pkg::ST_CHAR) && !still_q && pend_v_q;
	assign mem_we  = (state_q == fbe_pkg::ST_CHAR);

	// differential count, always taken at the current position
	assign d       = 32'(char_pos_q) - 32'(prev_cnt_q) + 32'(fbe_pkg::COUNT_OFFSET);
	assign d_small = (d <= 32'(2 * fbe_pkg::COUNT_OFFSET));

	// entry zero reads as a space until the first path writes it
	assign ent   = ((char_pos_q == '0) && !zero_wr_q) ? fbe_pkg::SPACE_CHAR : rd_q;
	assign match = (char_pos_q < prev_len_q) && (ent == c_q);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			path_mem[char_pos_q[PW-1:0]] <= c_q;
		end
		rd_q <= path_mem[char_pos_q[PW-1:0]];
	end

	fbe_pair_row #(
		.BIGRAM_PAIRS(BIGRAM_PAIRS),
		.IW          (IW)
	) u_row (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (tab_we),
		.wr_addr(fill_q[7:0]),
		.wr_byte(in_byte),
		.start  (start),
		.a      (pend_q),
		.b      (c_q),
		.srch   (srch),
		.idx    (idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fbe_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fbe_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (kind == fbe_pkg::KIND_TABLE) begin
						state_d = fbe_pkg::ST_EMIT;
					end else if (kind == fbe_pkg::KIND_CHAR && pos_ok) begin
						state_d = fbe_pkg::ST_CHAR;
					end else if (kind == fbe_pkg::KIND_EOL && (still_q || pend_v_q)) begin
						state_d = fbe_pkg::ST_EMIT;
					end
				end
			end
			fbe_pkg::ST_CHAR: begin
				if (still_q) begin
					state_d = match ? fbe_pkg::ST_IDLE : fbe_pkg::ST_EMIT;
				end else if (pend_v_q) begin
					state_d = fbe_pkg::ST_SEARCH;
				end else begin
					state_d = fbe_pkg::ST_IDLE;
				end
			end
			fbe_pkg::ST_SEARCH: begin
				if (srch.done) begin
					state_d = fbe_pkg::ST_EMIT;
				end
			end
			fbe_pkg::ST_EMIT: begin
				if (out_acc && last_e) begin
					state_d = fbe_pkg::ST_IDLE;
				end
			end
			default: state_d = fbe_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_pos_q <= '0;
			prev_len_q <= CPW'(1);
			prev_cnt_q <= '0;
			still_q    <= 1'b1;
			pend_q     <= '0;
			pend_v_q   <= 1'b0;
			fill_q     <= '0;
			zero_wr_q  <= 1'b0;
			n_q        <= '0;
			e_q        <= '0;
		end else begin
			unique case (state_q)
				fbe_pkg::ST_IDLE: begin
					e_q <= '0;
					if (in_acc && kind == fbe_pkg::KIND_TABLE) begin
						if (fill_ok) begin
							fill_q <= fill_q + 9'd1;
						end
						n_q <= 3'd1;
					end else if (in_acc && kind == fbe_pkg::KIND_EOL) begin
						if (still_q) begin
							prev_cnt_q <= char_pos_q;
							n_q        <= d_small ? 3'd1 : 3'd5;
						end else begin
							n_q <= 3'd1;
						end
						prev_len_q <= char_pos_q;
						char_pos_q <= '0;
						still_q    <= 1'b1;
						pend_v_q   <= 1'b0;
						pend_q     <= '0;
					end
				end
				fbe_pkg::ST_CHAR: begin
					char_pos_q <= char_pos_q + CPW'(1);
					if (char_pos_q == '0) begin
						zero_wr_q <= 1'b1;
					end
					if (still_q) begin
						if (!match) begin
							prev_cnt_q <= char_pos_q;
							n_q        <= d_small ? 3'd1 : 3'd5;
							still_q    <= 1'b0;
							pend_q     <= c_q;
							pend_v_q   <= 1'b1;
						end
					end else if (!pend_v_q) begin
						pend_q   <= c_q;
						pend_v_q <= 1'b1;
					end
				end
				fbe_pkg::ST_SEARCH: begin
					if (srch.done) begin
						n_q      <= srch.found ? 3'd1 : 3'd2;
						pend_v_q <= 1'b0;
					end
				end
				fbe_pkg::ST_EMIT: begin
					if (out_acc) begin
						e_q <= e_q + 3'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc && kind == fbe_pkg::KIND_CHAR) begin
			c_q <= fbe_pkg::clean_char(in_byte);
		end
		if (in_acc && kind == fbe_pkg::KIND_TABLE) begin
			buf_q[0] <= in_byte;
		end else if ((in_acc && kind == fbe_pkg::KIND_EOL && still_q)
				|| (state_q == fbe_pkg::ST_CHAR && still_q && !match)) begin
			buf_q[0] <= d_small ? d[7:0] : fbe_pkg::SWITCH_CODE;
			buf_q[1] <= d[7:0];
			buf_q[2] <= d[15:8];
			buf_q[3] <= d[23:16];
			buf_q[4] <= d[31:24];
		end else if (in_acc && kind == fbe_pkg::KIND_EOL) begin
			buf_q[0] <= {1'b0, pend_q};
		end else if (state_q == fbe_pkg::ST_SEARCH && srch.done) begin
			if (srch.found) begin
				buf_q[0] <= fbe_pkg::HIGH_BIT | 8'(idx);
			end else begin
				buf_q[0] <= {1'b0, pend_q};
				buf_q[1] <= {1'b0, c_q};
			end
		end
	end

	`FBE_ASSERT_SAME(a_one_side, out_valid, !in_ready)
	`FBE_ASSERT_SAME(a_emit_range, out_valid, (e_q < n_q) && (n_q != 3'd0))
	`FBE_ASSERT_NEXT(a_search_done, (state_q == fbe_pkg::ST_SEARCH) && srch.done,
		state_q == fbe_pkg::ST_EMIT)
	`FBE_ASSERT_SAME(a_pos_bound, 1'b1, char_pos_q <= CPW'(PATH_DEPTH))
endmodule
